// ===== sv/rpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the relative pose transform.
// No dependencies.
package rpt_pkg;

  localparam int RotFracBits = 15;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [31:0] pos_t;

  typedef struct packed {
    logic valid;
    logic cmd;
  } rpt_ctl_t;

  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdCompute = 1'b1;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/relative_pose_transform.sv =====
`timescale 1ns / 1ps
// Top level of the relative pose transform: reference pose store and pipeline control.
// Depends on rpt_pkg, rpt_quat_rot, rpt_rot_mul, rpt_trans.

// Six-stage pipeline that accepts one pose beat per cycle while in_stall_o is low.
// A load beat turns its quaternion into a rotation matrix and, once it has left the
// two rpt_quat_rot stages, replaces the reference pose; it yields no result. A compute
// beat yields one result: R = Rref * Rnew^T (Q1.15, saturated) and t = tref - R * tnew
// (saturated to 32 bits), using the reference left by all earlier beats. The whole
// pipeline advances together: when the output register holds an untaken result
// and out_stall_i is high, in_stall_o rises in the same cycle. Reset sets the
// reference to identity rotation and zero translation.
module relative_pose_transform #(
  parameter int RotFracBits = rpt_pkg::RotFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  r00_o,
  output logic signed [15:0]  r01_o,
  output logic signed [15:0]  r02_o,
  output logic signed [15:0]  r10_o,
  output logic signed [15:0]  r11_o,
  output logic signed [15:0]  r12_o,
  output logic signed [15:0]  r20_o,
  output logic signed [15:0]  r21_o,
  output logic signed [15:0]  r22_o,
  output logic signed [31:0]  trans_x_o,
  output logic signed [31:0]  trans_y_o,
  output logic signed [31:0]  trans_z_o
);

  localparam logic signed [15:0] Unit =
      (RotFracBits >= 15) ? 16'sh7fff : 16'(1 << RotFracBits);

  logic              adv;
  rpt_pkg::rpt_ctl_t in_ctl, s2_ctl;
  rpt_pkg::pos_t     pos_in [3];
  rpt_pkg::pos_t     s2_pos [3];
  rpt_pkg::q15_t     s2_rot [9];
  rpt_pkg::q15_t     rref_q [9];
  rpt_pkg::pos_t     tref_q [3];
  logic              s4_valid;
  rpt_pkg::q15_t     s4_rel [9];
  rpt_pkg::pos_t     s4_pos [3];
  rpt_pkg::pos_t     s4_tref [3];
  rpt_pkg::q15_t     out_rel [9];
  rpt_pkg::pos_t     out_tr [3];
  logic              ref_we;

  // advance every stage together unless a finished result is held
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  assign in_ctl.valid = in_valid_i;
  assign in_ctl.cmd   = command_i;
  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  rpt_quat_rot #(.RotFracBits(RotFracBits)) u_quat_rot (
    .clk_i, .rst_ni,
    .en_i  (adv),
    .ctl_i (in_ctl),
    .qw_i  (quat_w_i),
    .qx_i  (quat_x_i),
    .qy_i  (quat_y_i),
    .qz_i  (quat_z_i),
    .pos_i (pos_in),
    .ctl_o (s2_ctl),
    .rot_o (s2_rot),
    .pos_o (s2_pos)
  );

  // a load beat leaving stage two overwrites the reference
  assign ref_we = adv && s2_ctl.valid && (s2_ctl.cmd == rpt_pkg::CmdLoad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) rref_q[i] <= (i % 4 == 0) ? Unit : 16'sd0;
      for (int i = 0; i < 3; i++) tref_q[i] <= 32'sd0;
    end else if (ref_we) begin
      rref_q <= s2_rot;
      tref_q <= s2_pos;
    end
  end

  rpt_rot_mul #(.RotFracBits(RotFracBits)) u_rot_mul (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (s2_ctl.valid && (s2_ctl.cmd == rpt_pkg::CmdCompute)),
    .rref_i  (rref_q),
    .rnew_i  (s2_rot),
    .pos_i   (s2_pos),
    .tref_i  (tref_q),
    .valid_o (s4_valid),
    .rel_o   (s4_rel),
    .pos_o   (s4_pos),
    .tref_o  (s4_tref)
  );

  rpt_trans #(.RotFracBits(RotFracBits)) u_trans (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (s4_valid),
    .rel_i   (s4_rel),
    .pos_i   (s4_pos),
    .tref_i  (s4_tref),
    .valid_o (out_valid_o),
    .rel_o   (out_rel),
    .trans_o (out_tr)
  );

  assign r00_o = out_rel[0];
  assign r01_o = out_rel[1];
  assign r02_o = out_rel[2];
  assign r10_o = out_rel[3];
  assign r11_o = out_rel[4];
  assign r12_o = out_rel[5];
  assign r20_o = out_rel[6];
  assign r21_o = out_rel[7];
  assign r22_o = out_rel[8];
  assign trans_x_o = out_tr[0];
  assign trans_y_o = out_tr[1];
  assign trans_z_o = out_tr[2];

endmodule

// ===== sv/rpt_quat_rot.sv =====
`timescale 1ns / 1ps
// Quaternion to rotation matrix, two stages: products, then combine/round/saturate.
// Depends on rpt_pkg.
module rpt_quat_rot #(
  parameter int RotFracBits = rpt_pkg::RotFracBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rpt_pkg::rpt_ctl_t ctl_i,
  input  rpt_pkg::q15_t     qw_i,
  input  rpt_pkg::q15_t     qx_i,
  input  rpt_pkg::q15_t     qy_i,
  input  rpt_pkg::q15_t     qz_i,
  input  rpt_pkg::pos_t     pos_i [3],
  output rpt_pkg::rpt_ctl_t ctl_o,
  output rpt_pkg::q15_t     rot_o [9],
  output rpt_pkg::pos_t     pos_o [3]
);

  localparam int EW = (2 * RotFracBits + 3 > 36) ? 2 * RotFracBits + 3 : 36;
  localparam logic signed [EW-1:0] One  = EW'(1) << (2 * RotFracBits);
  localparam logic signed [EW-1:0] Half = EW'(1) << (RotFracBits - 1);

  rpt_pkg::rpt_ctl_t  ctl1_q, ctl2_q;
  logic signed [31:0] pr_d [9];
  logic signed [31:0] pr_q [9];
  rpt_pkg::pos_t      pos1_q [3];
  rpt_pkg::pos_t      pos2_q [3];
  rpt_pkg::q15_t      rot_d [9];
  rpt_pkg::q15_t      rot_q [9];
  logic signed [EW-1:0] ex [9];
  logic signed [EW-1:0] e  [9];

  // product order: xx yy zz xy wz xz wy yz wx
  always_comb begin
    pr_d[0] = qx_i * qx_i;
    pr_d[1] = qy_i * qy_i;
    pr_d[2] = qz_i * qz_i;
    pr_d[3] = qx_i * qy_i;
    pr_d[4] = qw_i * qz_i;
    pr_d[5] = qx_i * qz_i;
    pr_d[6] = qw_i * qy_i;
    pr_d[7] = qy_i * qz_i;
    pr_d[8] = qw_i * qx_i;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) ex[i] = EW'(pr_q[i]);
    e[0] = One - ((ex[1] + ex[2]) <<< 1);
    e[1] = (ex[3] - ex[4]) <<< 1;
    e[2] = (ex[5] + ex[6]) <<< 1;
    e[3] = (ex[3] + ex[4]) <<< 1;
    e[4] = One - ((ex[0] + ex[2]) <<< 1);
    e[5] = (ex[7] - ex[8]) <<< 1;
    e[6] = (ex[5] - ex[6]) <<< 1;
    e[7] = (ex[7] + ex[8]) <<< 1;
    e[8] = One - ((ex[0] + ex[1]) <<< 1);
    for (int i = 0; i < 9; i++) begin
      rot_d[i] = rpt_pkg::sat16(64'((e[i] + Half) >>> RotFracBits));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q   <= pr_d;
      pos1_q <= pos_i;
      rot_q  <= rot_d;
      pos2_q <= pos1_q;
    end
  end

  assign ctl_o = ctl2_q;
  assign rot_o = rot_q;
  assign pos_o = pos2_q;

endmodule

// ===== sv/rpt_rot_mul.sv =====
`timescale 1ns / 1ps
// Relative rotation Rref * Rnew^T, two stages: 27 products, then sum/round/saturate.
// Depends on rpt_pkg.
module rpt_rot_mul #(
  parameter int RotFracBits = rpt_pkg::RotFracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpt_pkg::q15_t rref_i [9],
  input  rpt_pkg::q15_t rnew_i [9],
  input  rpt_pkg::pos_t pos_i  [3],
  input  rpt_pkg::pos_t tref_i [3],
  output logic          valid_o,
  output rpt_pkg::q15_t rel_o  [9],
  output rpt_pkg::pos_t pos_o  [3],
  output rpt_pkg::pos_t tref_o [3]
);

  localparam logic signed [34:0] Half = 35'(1) << (RotFracBits - 1);

  logic               v3_q, v4_q;
  logic signed [31:0] m_d [27];
  logic signed [31:0] m_q [27];
  rpt_pkg::q15_t      rel_d [9];
  rpt_pkg::q15_t      rel_q [9];
  rpt_pkg::pos_t      pos3_q [3];
  rpt_pkg::pos_t      pos4_q [3];
  rpt_pkg::pos_t      tref3_q [3];
  rpt_pkg::pos_t      tref4_q [3];
  logic signed [34:0] acc [9];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++)
          m_d[(i*3+j)*3+k] = rref_i[i*3+k] * rnew_i[j*3+k];
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      acc[n] = 35'(m_q[n*3]) + 35'(m_q[n*3+1]) + 35'(m_q[n*3+2]);
      rel_d[n] = rpt_pkg::sat16(64'((acc[n] + Half) >>> RotFracBits));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_d;
      pos3_q  <= pos_i;
      tref3_q <= tref_i;
      rel_q   <= rel_d;
      pos4_q  <= pos3_q;
      tref4_q <= tref3_q;
    end
  end

  assign valid_o = v4_q;
  assign rel_o   = rel_q;
  assign pos_o   = pos4_q;
  assign tref_o  = tref4_q;

endmodule

// ===== sv/rpt_trans.sv =====
`timescale 1ns / 1ps
// Relative translation tref - R * tnew, two stages: 9 products, then sum/round/saturate.
// Holds the output registers. Depends on rpt_pkg.
module rpt_trans #(
  parameter int RotFracBits = rpt_pkg::RotFracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpt_pkg::q15_t rel_i  [9],
  input  rpt_pkg::pos_t pos_i  [3],
  input  rpt_pkg::pos_t tref_i [3],
  output logic          valid_o,
  output rpt_pkg::q15_t rel_o  [9],
  output rpt_pkg::pos_t trans_o [3]
);

  localparam logic signed [50:0] Half = 51'(1) << (RotFracBits - 1);

  logic               v5_q, v6_q;
  logic signed [47:0] p_d [9];
  logic signed [47:0] p_q [9];
  rpt_pkg::q15_t      rel5_q [9];
  rpt_pkg::q15_t      rel6_q [9];
  rpt_pkg::pos_t      tref5_q [3];
  rpt_pkg::pos_t      tr_d [3];
  rpt_pkg::pos_t      tr_q [3];
  logic signed [50:0] acc [3];
  logic signed [51:0] t [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        p_d[i*3+k] = rel_i[i*3+k] * pos_i[k];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = 51'(p_q[i*3]) + 51'(p_q[i*3+1]) + 51'(p_q[i*3+2]);
      t[i]    = 52'(tref5_q[i]) - 52'((acc[i] + Half) >>> RotFracBits);
      tr_d[i] = rpt_pkg::sat32(64'(t[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      rel5_q  <= rel_i;
      tref5_q <= tref_i;
      rel6_q  <= rel5_q;
      tr_q    <= tr_d;
    end
  end

  assign valid_o = v6_q;
  assign rel_o   = rel6_q;
  assign trans_o = tr_q;

endmodule

// ===== sv/rpt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for relative_pose_transform, attached by bind.
// Depends on relative_pose_transform.
module rpt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] r00_o,
  input logic signed [31:0] trans_x_o
);

  // a held result backs up the input side in the same cycle
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("result held but input not stalled");

  // with no result pending the input side is never stalled
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(r00_o) && $stable(trans_x_o)))
    else $error("stalled result changed");

endmodule

bind relative_pose_transform rpt_checker u_rpt_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .r00_o, .trans_x_o
);

// ===== verif/tb_relative_pose_transform.sv =====
`timescale 1ns / 1ps
// Self-checking bench for relative_pose_transform: random pose beats with idle gaps,
// an in-bench fixed-point predictor and an in-order result check. Depends on rpt_pkg.
module tb_relative_pose_transform;

  typedef struct packed {
    logic cmd;
    rpt_pkg::q15_t qw, qx, qy, qz;
    rpt_pkg::pos_t px, py, pz;
  } pose_t;

  typedef struct packed {
    rpt_pkg::q15_t [8:0] rot;
    rpt_pkg::pos_t [2:0] tr;
  } rel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  rpt_pkg::q15_t quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  rpt_pkg::pos_t pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rpt_pkg::q15_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;
  rpt_pkg::pos_t trans_x_o, trans_y_o, trans_z_o;

  relative_pose_transform dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pose_t         pending_poses[$];
  rel_t          expected_rel[$];
  rpt_pkg::q15_t ref_rot[9];
  rpt_pkg::pos_t ref_pos[3];
  int    errors = 0;
  int    n_loads = 0, n_computes = 0, n_results = 0;
  bit    hold_sender = 1'b0;
  bit    stim_done = 1'b0;
  // handshakes seen at the last rising edge
  bit    in_fire = 1'b0;
  bit    out_fire = 1'b0;

  function automatic longint round_q(longint v);
    return (v + (64'sd1 <<< (rpt_pkg::RotFracBits - 1))) >>> rpt_pkg::RotFracBits;
  endfunction

  function automatic void pose_rotation(pose_t p, output rpt_pkg::q15_t r[9]);
    longint w, x, y, z, one;
    longint e[9];
    w = p.qw; x = p.qx; y = p.qy; z = p.qz;
    one = 64'sd1 <<< (2 * rpt_pkg::RotFracBits);
    e[0] = one - 2 * (y * y + z * z);
    e[1] = 2 * (x * y - w * z);
    e[2] = 2 * (x * z + w * y);
    e[3] = 2 * (x * y + w * z);
    e[4] = one - 2 * (x * x + z * z);
    e[5] = 2 * (y * z - w * x);
    e[6] = 2 * (x * z - w * y);
    e[7] = 2 * (y * z + w * x);
    e[8] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 9; i++) r[i] = rpt_pkg::sat16(round_q(e[i]));
  endfunction

  // Update the reference on loads, queue the relative pose on computes.
  function automatic void predict_relative(pose_t p);
    rpt_pkg::q15_t rn[9];
    longint tn[3];
    longint acc;
    rel_t res;
    pose_rotation(p, rn);
    tn[0] = p.px; tn[1] = p.py; tn[2] = p.pz;
    if (p.cmd == rpt_pkg::CmdLoad) begin
      for (int i = 0; i < 9; i++) ref_rot[i] = rn[i];
      for (int i = 0; i < 3; i++) ref_pos[i] = rpt_pkg::pos_t'(tn[i]);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += longint'(ref_rot[i*3+k]) * longint'(rn[j*3+k]);
        res.rot[i*3+j] = rpt_pkg::sat16(round_q(acc));
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += longint'(res.rot[i*3+k]) * tn[k];
      res.tr[i] = rpt_pkg::sat32(longint'(ref_pos[i]) - round_q(acc));
    end
    expected_rel.push_back(res);
  endfunction

  function automatic rpt_pkg::q15_t rand_q(int mode);
    unique case (mode)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return rpt_pkg::q15_t'($urandom_range(0, 8191)) - 16'sd4096;
      default: return rpt_pkg::q15_t'($urandom());
    endcase
  endfunction

  function automatic pose_t rand_pose(logic cmd);
    pose_t p;
    int m;
    p.cmd = cmd;
    m = $urandom_range(0, 9);
    p.qw = rand_q(m < 3 ? 4 : $urandom_range(0, 4));
    p.qx = rand_q($urandom_range(0, 4));
    p.qy = rand_q($urandom_range(0, 4));
    p.qz = rand_q($urandom_range(0, 4));
    p.px = ($urandom_range(0, 3) == 0) ? rpt_pkg::pos_t'($urandom())
                                       : rpt_pkg::pos_t'($urandom_range(0, 2**20)) - 2**19;
    p.py = rpt_pkg::pos_t'($urandom());
    p.pz = ($urandom_range(0, 5) == 0) ? 32'sh80000000 : rpt_pkg::pos_t'($urandom());
    return p;
  endfunction

  function automatic pose_t make_pose(logic cmd, rpt_pkg::q15_t w, rpt_pkg::q15_t x,
                                      rpt_pkg::q15_t y, rpt_pkg::q15_t z,
                                      rpt_pkg::pos_t px, rpt_pkg::pos_t py,
                                      rpt_pkg::pos_t pz);
    pose_t p;
    p.cmd = cmd; p.qw = w; p.qx = x; p.qy = y; p.qz = z;
    p.px = px; p.py = py; p.pz = pz;
    return p;
  endfunction

  initial begin
    for (int i = 0; i < 9; i++)
      ref_rot[i] = (i % 4 == 0) ? rpt_pkg::sat16(64'sd1 <<< rpt_pkg::RotFracBits) : '0;
    for (int i = 0; i < 3; i++) ref_pos[i] = '0;
    // Compute against the reset reference, identity and zero quaternions, extremes.
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, 16'sh7fff, '0, '0, '0,
                                      32'sd65536, -32'sd65536, 0));
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, '0, '0, '0, '0,
                                      32'sh7fffffff, 32'sh80000000, 1));
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, 16'sh8000, 16'sh8000, 16'sh8000,
                                      16'sh8000, 32'sh7fffffff, 32'sh7fffffff,
                                      32'sh80000000));
    pending_poses.push_back(make_pose(rpt_pkg::CmdLoad, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                      16'sh7fff, 32'sh80000000, 32'sh7fffffff, -1));
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                      16'sh8000, 32'sh7fffffff, 32'sh80000000,
                                      32'sh7fffffff));
    pending_poses.push_back(make_pose(rpt_pkg::CmdLoad, '0, 16'sh5a82, '0, 16'sh5a82,
                                      32'sd12345, 0, -5));
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, 16'sh5a82, '0, 16'sh5a82, '0,
                                      -1, -1, -1));
    pending_poses.push_back(make_pose(rpt_pkg::CmdLoad, '0, '0, '0, '0, 0, 0, 0));
    pending_poses.push_back(make_pose(rpt_pkg::CmdCompute, 16'sh4000, 16'sh4000, 16'sh4000,
                                      16'sh4000, 32'sd1 <<< 20, 32'sd3, -32'sd7));
    pending_poses.push_back(make_pose(rpt_pkg::CmdLoad, 16'sh7fff, '0, '0, '0, 0, 0, 0));
    for (int i = 0; i < 950; i++) begin
      if (i == 475) pending_poses.push_back(rand_pose(rpt_pkg::CmdLoad));
      pending_poses.push_back(rand_pose(($urandom_range(0, 9) == 0) ? rpt_pkg::CmdLoad
                                                                     : rpt_pkg::CmdCompute));
    end
    stim_done = 1'b1;
  end

  // Driver: one beat per pending pose, random gap before each.
  int send_gap = 0;
  int sent = 0;
  pose_t cur;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        sent++;
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        if (sent == 400) hold_sender = 1'b1;
      end
      // hold a stalled beat, otherwise load the next one or drop valid
      if (!in_valid_i || in_fire) begin
        if (hold_sender && expected_rel.size() == 0) hold_sender = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!hold_sender && pending_poses.size() > 0) begin
          cur = pending_poses.pop_front();
          in_valid_i <= 1'b1;
          command_i <= cur.cmd;
          quat_w_i <= cur.qw; quat_x_i <= cur.qx; quat_y_i <= cur.qy; quat_z_i <= cur.qz;
          pos_x_i <= cur.px; pos_y_i <= cur.py; pos_z_i <= cur.pz;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: per result, draw a wait.
  int recv_wait = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire)
        recv_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
      if (recv_wait > 0) begin
        out_stall_i <= 1'b1;
        recv_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Predict on accepted input beats, check accepted result beats.
  rel_t exp_r;
  rel_t got;
  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      if (command_i == rpt_pkg::CmdLoad) n_loads++; else n_computes++;
      predict_relative(make_pose(command_i, quat_w_i, quat_x_i, quat_y_i, quat_z_i,
                                 pos_x_i, pos_y_i, pos_z_i));
    end
    if (out_fire) begin
      got.rot = {r22_o, r21_o, r20_o, r12_o, r11_o, r10_o, r02_o, r01_o, r00_o};
      got.tr = {trans_z_o, trans_y_o, trans_x_o};
      n_results++;
      if (expected_rel.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_r = expected_rel.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.rot[i] !== exp_r.rot[i]) begin
            $error("r%0d%0d expected %0d got %0d", i / 3, i % 3, exp_r.rot[i], got.rot[i]);
            errors++;
          end
        for (int i = 0; i < 3; i++)
          if (got.tr[i] !== exp_r.tr[i]) begin
            $error("trans_%s expected %0d got %0d", i == 0 ? "x" : (i == 1 ? "y" : "z"),
                   exp_r.tr[i], got.tr[i]);
            errors++;
          end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (stim_done && pending_poses.size() == 0 && !in_valid_i);
    wait (expected_rel.size() == 0);
    repeat (40) @(posedge clk_i);
    if (expected_rel.size() != 0) errors++;
    $display("covered %0d load and %0d compute beats, %0d results checked",
             n_loads, n_computes, n_results);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rpt_pkg.sv
sv/rpt_quat_rot.sv
sv/rpt_rot_mul.sv
sv/rpt_trans.sv
sv/relative_pose_transform.sv
sv/rpt_checker.sv
verif/tb_relative_pose_transform.sv
